>>> rtl/core/ccal_pkg.sv
package ccal_pkg;

  localparam int NUM_BINS   = 10;
  localparam int HIST_DEPTH = 256;

  localparam int CONF_W   = 17;
  localparam int FRAC_W   = 16;
  localparam int CNT_W    = 32;
  localparam int FACT_W   = 18;
  localparam int PERIOD_W = 16;
  localparam int MINS_W   = 16;
  localparam int ONE_Q16  = 65536;

  localparam int BIN_AW  = $clog2(NUM_BINS);
  localparam int HIST_AW = $clog2(HIST_DEPTH);
  localparam int FILL_W  = $clog2(HIST_DEPTH + 1);
  localparam int TWO_N   = 2 * NUM_BINS;
  localparam int TWO_N_W = $clog2(TWO_N + 1);
  localparam int SQ_W    = 2 * CONF_W - 1;
  localparam int SUM_W   = CNT_W + FILL_W;
  localparam int DIV_DW  = CNT_W + TWO_N_W;
  localparam int ECE_S_W = DIV_DW + BIN_AW;
  localparam int DIV_NW  = ECE_S_W + FRAC_W;
  localparam int CNT_DW  = $clog2(DIV_NW + 1);

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [CONF_W-1:0] ONE_C = CONF_W'(ONE_Q16);

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_RECAL_PERIOD   = 2'd0;
  localparam reg_idx_t REG_MIN_SAMPLES    = 2'd1;
  localparam reg_idx_t REG_FACTOR_FLOOR   = 2'd2;
  localparam reg_idx_t REG_FACTOR_CEILING = 2'd3;

  typedef struct packed {
    logic [FACT_W-1:0] factor;
    logic [CNT_W-1:0]  correct;
    logic [CNT_W-1:0]  pred;
  } bin_ent_t;

  typedef struct packed {
    logic              ok;
    logic [CONF_W-1:0] conf;
  } hist_ent_t;

  localparam int BENT_W = $bits(bin_ent_t);
  localparam int HENT_W = $bits(hist_ent_t);

endpackage

>>> rtl/core/ccal_ram.sv
module ccal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/ccal_div.sv
module ccal_div
  import ccal_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quo
);

  logic [DIV_NW-1:0] q_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [CNT_DW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DIV_DW:0]   sh_c;
  logic              ge_c;
  logic [DIV_DW:0]   diff_c;

  always_comb begin
    sh_c   = {rem_r, q_r[DIV_NW-1]};
    ge_c   = sh_c >= {1'b0, den_r};
    diff_c = sh_c - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_DW'(DIV_NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_DW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= {q_r[DIV_NW-2:0], ge_c};
      rem_r <= ge_c ? diff_c[DIV_DW-1:0] : sh_c[DIV_DW-1:0];
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

>>> rtl/core/confidence_calibration_engine.sv
// Channel  Direction  Handshake          Payload
// in_      input      in_valid/in_stall  in_action, in_confidence, in_was_correct
// out_     output     out_valid/out_stall out_calibrated, out_brier, out_ece
// cfg      APB        psel/penable/pready paddr, pwdata, prdata
//
// Calibrate: bin memory read, multiply, result register, in that order.
// Record: the time is set by the bin walk and two runs of the shared bit-serial divider
// (ECE, then Brier); a recalibration adds a walk over the bins, with a divider run for
// each updated bin that holds samples.
// After reset the bin memory is cleared, one entry a cycle.
// The next item is taken while a result waits under out_stall.
module confidence_calibration_engine
  import ccal_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic [CONF_W-1:0]  in_confidence,
  input  logic               in_was_correct,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CONF_W-1:0]  out_calibrated,
  output logic [CONF_W-1:0]  out_brier,
  output logic [CONF_W-1:0]  out_ece,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_LOAD, S_SQ, S_SUM,
    S_RC_RD, S_RC_CHK, S_RC_GO, S_RC_WAIT, S_RC_WR, S_RC_NEXT,
    S_E_RD, S_E_MUL, S_E_SUM, S_E_PREP, S_E_GO, S_E_WAIT,
    S_B_PREP, S_B_GO, S_B_WAIT, S_FIN
  } state_t;

  state_t state_r;

  logic [BIN_AW-1:0]   idx_r;
  logic                act_r;
  logic                ok_r;
  logic [CONF_W-1:0]   conf_r;
  logic [BIN_AW-1:0]   bin_r;
  logic                full_r;
  logic                rc_r;
  logic [SQ_W-1:0]     sqn_r;
  logic [SQ_W-1:0]     sqo_r;
  logic [HIST_AW-1:0]  widx_r;
  logic [FILL_W-1:0]   fill_r;
  logic [CNT_W-1:0]    total_r;
  logic [SUM_W-1:0]    sum_r;
  logic [PERIOD_W-1:0] cd_r;
  logic [PERIOD_W-1:0] period_r;
  logic [MINS_W-1:0]   mins_r;
  logic [FACT_W-1:0]   floor_r;
  logic [FACT_W-1:0]   ceil_r;
  logic [CONF_W-1:0]   brier_r;
  logic [CONF_W-1:0]   ece_r;
  logic [CONF_W+FACT_W-1:0] prod_r;
  logic [FACT_W-1:0]   f_r;
  logic [ECE_S_W-1:0]  s_r;
  logic [DIV_DW-1:0]   a_r;
  logic [DIV_DW-1:0]   b_r;
  logic [DIV_NW-1:0]   dnum_r;
  logic [DIV_DW-1:0]   dden_r;
  logic                out_valid_r;
  logic [CONF_W-1:0]   out_cal_r;
  logic [CONF_W-1:0]   out_brier_r;
  logic [CONF_W-1:0]   out_ece_r;

  logic                      in_acc;
  logic                      cfg_wr;
  logic                      out_free;
  logic [CONF_W-1:0]         conf_in_c;
  logic [CONF_W+TWO_N_W-1:0] bprod_c;
  logic [TWO_N_W:0]          bq_c;
  logic [BIN_AW-1:0]         bin_in_c;
  logic [CONF_W-1:0]         dnew_c;
  logic [CONF_W-1:0]         dold_c;
  logic [2*CONF_W-1:0]       sqn_c;
  logic [2*CONF_W-1:0]       sqo_c;
  logic                      sat_c;
  logic [DIV_DW-1:0]         odd_c;
  logic [CONF_W+FACT_W-FRAC_W-1:0] cal_c;
  logic [DIV_NW-FRAC_W-1:0]  bq16_c;
  logic                      last_c;

  bin_ent_t  bin_rdata;
  bin_ent_t  bin_wdata;
  hist_ent_t hist_rdata;
  hist_ent_t hist_wdata;
  logic              bin_we;
  logic              bin_re;
  logic [BIN_AW-1:0] bin_waddr;
  logic [BIN_AW-1:0] bin_raddr;
  logic              hist_we;
  logic              div_start;
  logic              div_done;
  logic [DIV_NW-1:0] div_quo;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign cfg_wr   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign out_free = !out_valid_r || !out_stall;
  assign last_c   = (idx_r == BIN_AW'(NUM_BINS - 1));

  always_comb begin
    conf_in_c = (in_confidence > ONE_C) ? ONE_C : in_confidence;
    bprod_c   = {{TWO_N_W{1'b0}}, conf_in_c} * (CONF_W+TWO_N_W)'(NUM_BINS);
    bq_c      = bprod_c[CONF_W+TWO_N_W-1:FRAC_W];
    bin_in_c  = (bq_c >= (TWO_N_W+1)'(NUM_BINS)) ? BIN_AW'(NUM_BINS - 1) : bq_c[BIN_AW-1:0];
    dnew_c    = ok_r ? (ONE_C - conf_r) : conf_r;
    dold_c    = hist_rdata.ok ? (ONE_C - hist_rdata.conf) : hist_rdata.conf;
    sqn_c     = {{CONF_W{1'b0}}, dnew_c} * {{CONF_W{1'b0}}, dnew_c};
    sqo_c     = {{CONF_W{1'b0}}, dold_c} * {{CONF_W{1'b0}}, dold_c};
    sat_c     = (bin_rdata.pred == '1);
    odd_c     = DIV_DW'({idx_r, 1'b1});
    cal_c     = prod_r[CONF_W+FACT_W-1:FRAC_W];
    bq16_c    = div_quo[DIV_NW-1:FRAC_W];
  end

  always_comb begin
    bin_we    = 1'b0;
    bin_re    = 1'b0;
    bin_waddr = idx_r;
    bin_raddr = idx_r;
    bin_wdata = bin_rdata;
    case (state_r)
      S_CLR: begin
        bin_we    = 1'b1;
        bin_wdata = '{factor: FACT_W'(ONE_Q16), correct: '0, pred: '0};
      end
      S_IDLE: begin
        bin_re    = in_acc;
        bin_raddr = bin_in_c;
      end
      S_LOAD: begin
        bin_we    = act_r;
        bin_waddr = bin_r;
        if (!sat_c) begin
          bin_wdata.pred    = bin_rdata.pred + 1'b1;
          bin_wdata.correct = bin_rdata.correct + CNT_W'(ok_r);
        end
      end
      S_RC_RD, S_E_RD: begin
        bin_re = 1'b1;
      end
      S_RC_WR: begin
        bin_we           = 1'b1;
        bin_wdata.factor = (f_r < floor_r) ? floor_r : f_r;
      end
      default: begin
        bin_we = 1'b0;
      end
    endcase
  end

  assign hist_we    = (state_r == S_LOAD) && act_r;
  assign hist_wdata = '{ok: ok_r, conf: conf_r};
  assign div_start  = (state_r == S_RC_GO) || (state_r == S_E_GO) || (state_r == S_B_GO);

  ccal_ram #(.WIDTH(BENT_W), .DEPTH(NUM_BINS)) u_bin_ram (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .re    (bin_re),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  ccal_ram #(.WIDTH(HENT_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (widx_r),
    .wdata (hist_wdata),
    .re    (in_acc),
    .raddr (widx_r),
    .rdata (hist_rdata)
  );

  ccal_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (dnum_r),
    .den   (dden_r),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    case (paddr[3:2])
      REG_RECAL_PERIOD:   prdata = PDATA_W'(period_r);
      REG_MIN_SAMPLES:    prdata = PDATA_W'(mins_r);
      REG_FACTOR_FLOOR:   prdata = PDATA_W'(floor_r);
      REG_FACTOR_CEILING: prdata = PDATA_W'(ceil_r);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      widx_r      <= '0;
      fill_r      <= '0;
      total_r     <= '0;
      sum_r       <= '0;
      cd_r        <= PERIOD_W'(100);
      period_r    <= PERIOD_W'(100);
      mins_r      <= MINS_W'(5);
      floor_r     <= FACT_W'(32768);
      ceil_r      <= FACT_W'(98304);
      brier_r     <= '0;
      ece_r       <= '0;
      out_valid_r <= 1'b0;
      rc_r        <= 1'b0;
      act_r       <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_RECAL_PERIOD: begin
            period_r <= pwdata[PERIOD_W-1:0];
            cd_r     <= pwdata[PERIOD_W-1:0];
          end
          REG_MIN_SAMPLES:    mins_r  <= pwdata[MINS_W-1:0];
          REG_FACTOR_FLOOR:   floor_r <= pwdata[FACT_W-1:0];
          REG_FACTOR_CEILING: ceil_r  <= pwdata[FACT_W-1:0];
          default:            mins_r  <= mins_r;
        endcase
      end
      case (state_r)
        S_CLR: begin
          idx_r <= idx_r + 1'b1;
          if (last_c) begin
            idx_r   <= '0;
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            act_r   <= in_action;
            ok_r    <= in_was_correct;
            conf_r  <= conf_in_c;
            bin_r   <= bin_in_c;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (!act_r) begin
            prod_r  <= {{FACT_W{1'b0}}, conf_r} * {{CONF_W{1'b0}}, bin_rdata.factor};
            state_r <= S_FIN;
          end else begin
            sqn_r <= sqn_c[SQ_W-1:0];
            if (total_r != '1) begin
              total_r <= total_r + 1'b1;
            end
            full_r <= (fill_r == FILL_W'(HIST_DEPTH));
            if (fill_r != FILL_W'(HIST_DEPTH)) begin
              fill_r <= fill_r + 1'b1;
            end
            widx_r <= (widx_r == HIST_AW'(HIST_DEPTH - 1)) ? '0 : widx_r + 1'b1;
            if (cd_r <= PERIOD_W'(1)) begin
              rc_r <= 1'b1;
              cd_r <= period_r;
            end else begin
              rc_r <= 1'b0;
              cd_r <= cd_r - 1'b1;
            end
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          sqo_r   <= sqo_c[SQ_W-1:0];
          state_r <= S_SUM;
        end
        S_SUM: begin
          sum_r   <= sum_r - (full_r ? SUM_W'(sqo_r) : '0) + SUM_W'(sqn_r);
          idx_r   <= '0;
          s_r     <= '0;
          state_r <= rc_r ? S_RC_RD : S_E_RD;
        end
        S_RC_RD: state_r <= S_RC_CHK;
        S_RC_CHK: begin
          if (bin_rdata.pred < CNT_W'(mins_r)) begin
            state_r <= S_RC_NEXT;
          end else if (bin_rdata.pred == '0) begin
            f_r     <= '0;
            state_r <= S_RC_WR;
          end else begin
            dnum_r  <= (DIV_NW'(bin_rdata.correct) * DIV_NW'(TWO_N)) << FRAC_W;
            dden_r  <= DIV_DW'(bin_rdata.pred) * odd_c;
            state_r <= S_RC_GO;
          end
        end
        S_RC_GO: state_r <= S_RC_WAIT;
        S_RC_WAIT: begin
          if (div_done) begin
            f_r     <= (div_quo > DIV_NW'(ceil_r)) ? ceil_r : div_quo[FACT_W-1:0];
            state_r <= S_RC_WR;
          end
        end
        S_RC_WR: state_r <= S_RC_NEXT;
        S_RC_NEXT: begin
          if (last_c) begin
            idx_r   <= '0;
            s_r     <= '0;
            state_r <= S_E_RD;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_RC_RD;
          end
        end
        S_E_RD: state_r <= S_E_MUL;
        S_E_MUL: begin
          if (bin_rdata.pred == '0) begin
            a_r <= '0;
            b_r <= '0;
          end else begin
            a_r <= DIV_DW'(bin_rdata.correct) * DIV_DW'(TWO_N);
            b_r <= DIV_DW'(bin_rdata.pred) * odd_c;
          end
          state_r <= S_E_SUM;
        end
        S_E_SUM: begin
          s_r <= s_r + ECE_S_W'((a_r >= b_r) ? (a_r - b_r) : (b_r - a_r));
          if (last_c) begin
            state_r <= S_E_PREP;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_E_RD;
          end
        end
        S_E_PREP: begin
          dnum_r  <= {s_r, {FRAC_W{1'b0}}};
          dden_r  <= DIV_DW'(total_r) * DIV_DW'(TWO_N);
          state_r <= S_E_GO;
        end
        S_E_GO: state_r <= S_E_WAIT;
        S_E_WAIT: begin
          if (div_done) begin
            ece_r   <= (div_quo > DIV_NW'(ONE_Q16)) ? ONE_C : div_quo[CONF_W-1:0];
            state_r <= S_B_PREP;
          end
        end
        S_B_PREP: begin
          dnum_r  <= DIV_NW'(sum_r);
          dden_r  <= DIV_DW'(fill_r);
          state_r <= S_B_GO;
        end
        S_B_GO: state_r <= S_B_WAIT;
        S_B_WAIT: begin
          if (div_done) begin
            brier_r <= (bq16_c > (DIV_NW-FRAC_W)'(ONE_Q16)) ? ONE_C : bq16_c[CONF_W-1:0];
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_brier_r <= brier_r;
            out_ece_r   <= ece_r;
            if (act_r) begin
              out_cal_r <= '0;
            end else begin
              out_cal_r <= (cal_c > (CONF_W+FACT_W-FRAC_W)'(ONE_Q16)) ?
                           ONE_C : cal_c[CONF_W-1:0];
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_calibrated = out_cal_r;
  assign out_brier      = out_brier_r;
  assign out_ece        = out_ece_r;

  a_ece_range: assert property (@(posedge clk) disable iff (!rst_n)
    ece_r <= ONE_C) else $error("ece above one");

  a_brier_range: assert property (@(posedge clk) disable iff (!rst_n)
    brier_r <= ONE_C) else $error("brier above one");

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(HIST_DEPTH)) else $error("fill count overflow");

  a_widx_track: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != FILL_W'(HIST_DEPTH)) |-> (widx_r == fill_r[HIST_AW-1:0]))
    else $error("write index out of step with fill count");

  a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && out_valid_r && out_stall) |=> (state_r == S_FIN))
    else $error("result overwritten while output held");

endmodule
